/* src/pad_arpeggiator_top_macros.svh */
`ifndef PAD_ARPEGGIATOR_TOP_MACROS_SVH
`define PAD_ARPEGGIATOR_TOP_MACROS_SVH

// Same-cycle implication, checked on every clock outside reset
`define ARP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock outside reset
`define ARP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/pad_arp_pkg.sv */
package pad_arp_pkg;

    // Limits and field widths
    localparam int DEF_MAX_PADS = 16;
    localparam int OPC_W        = 2;
    localparam int PAD_W        = 4;
    localparam int VEL_W        = 16;
    localparam int DELAY_W      = 16;
    localparam int FRAC_W       = 16;
    localparam int TIME_W       = 40;
    localparam int GEN_W        = 64;
    localparam int CNT_CFG_W    = 5;
    localparam int DATA_W       = 64;
    localparam int ADDR_W       = 6;
    localparam int IDX_W        = 3;
    localparam int MUL_W        = 32;

    // Random pick: r >> 11 scaled by pad count, top bits from 53 up
    localparam int RND_SHIFT = 11;
    localparam int RND_POS   = 53;

    localparam logic [TIME_W-1:0]    ONE_SAMPLE   = TIME_W'(64'h1_0000);
    localparam logic [TIME_W-1:0]    RST_INTERVAL = TIME_W'(64'd1179648);
    localparam logic [CNT_CFG_W-1:0] RST_PADS     = CNT_CFG_W'(16);
    localparam logic [GEN_W-1:0]     RST_SEED     = GEN_W'(1);
    localparam logic [GEN_W-1:0]     STAR_MUL     = 64'h2545_F491_4F6C_DD1D;

    typedef enum logic [OPC_W-1:0] {
        OP_TICK    = 2'd0,
        OP_HOLD    = 2'd1,
        OP_RELEASE = 2'd2
    } t_opcode;

    typedef enum logic [IDX_W-1:0] {
        REG_ENABLE   = 3'd0,
        REG_DIR      = 3'd1,
        REG_RANDOM   = 3'd2,
        REG_PADS     = 3'd3,
        REG_INTERVAL = 3'd4,
        REG_SEED     = 3'd5
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RED_H,
        S_RED_P,
        S_STEP,
        S_MUL_A,
        S_MUL_B,
        S_MUL_C,
        S_MUL_D,
        S_MUL_E,
        S_MUL_F,
        S_MUL_G,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                 arp_enabled;
        logic                 direction_down;
        logic                 random_order;
        logic [CNT_CFG_W-1:0] pads_in_use;
        logic [TIME_W-1:0]    fire_interval;
        logic [GEN_W-1:0]     random_seed;
    } t_cfg;

    typedef struct packed {
        logic             disable_hold;
        logic             load_seed;
        logic [GEN_W-1:0] seed;
    } t_cfg_evt;

    // xorshift step with shifts 12, 25, 27
    function automatic logic [GEN_W-1:0] xorshift(input logic [GEN_W-1:0] s_in);
        logic [GEN_W-1:0] s;
        s = s_in;
        s = s ^ (s >> 12);
        s = s ^ (s << 25);
        s = s ^ (s >> 27);
        return s;
    endfunction

endpackage

/* src/pad_arp_mul.sv */
module pad_arp_mul (
    input  logic                             i_clk,
    input  logic [pad_arp_pkg::MUL_W-1:0]    i_a,
    input  logic [pad_arp_pkg::MUL_W-1:0]    i_b,
    output logic [2*pad_arp_pkg::MUL_W-1:0]  o_prod
);
    import pad_arp_pkg::*;

    logic [2*MUL_W-1:0] r_prod;

    // Shared 32x32 multiplier, product registered
    always_ff @(posedge i_clk) begin
        r_prod <= (2*MUL_W)'(i_a) * (2*MUL_W)'(i_b);
    end

    assign o_prod = r_prod;

endmodule

/* src/pad_arp_regs.sv */
module pad_arp_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pad_arp_pkg::ADDR_W-1:0] paddr,
    input  logic [pad_arp_pkg::DATA_W-1:0] pwdata,
    output logic [pad_arp_pkg::DATA_W-1:0] prdata,
    output logic                           pready,
    output pad_arp_pkg::t_cfg              o_cfg,
    output pad_arp_pkg::t_cfg_evt          o_evt
);
    import pad_arp_pkg::*;

    t_cfg             r_cfg;
    t_cfg             n_cfg;
    t_cfg_evt         cfg_evt;
    logic             wr_en;
    logic [IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[ADDR_W-1:ADDR_W-IDX_W];

    // Register writes and the side effects the sequencer needs to see
    always_comb begin
        n_cfg                = r_cfg;
        cfg_evt.disable_hold = 1'b0;
        cfg_evt.load_seed    = 1'b0;
        cfg_evt.seed         = pwdata;
        if (wr_en) begin
            case (idx)
                REG_ENABLE: begin
                    n_cfg.arp_enabled    = pwdata[0];
                    cfg_evt.disable_hold = !pwdata[0];
                end
                REG_DIR:      n_cfg.direction_down = pwdata[0];
                REG_RANDOM:   n_cfg.random_order   = pwdata[0];
                REG_PADS:     n_cfg.pads_in_use    = pwdata[CNT_CFG_W-1:0];
                REG_INTERVAL: n_cfg.fire_interval  = pwdata[TIME_W-1:0];
                REG_SEED: begin
                    n_cfg.random_seed = pwdata;
                    cfg_evt.load_seed = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.arp_enabled    <= 1'b0;
            r_cfg.direction_down <= 1'b0;
            r_cfg.random_order   <= 1'b0;
            r_cfg.pads_in_use    <= RST_PADS;
            r_cfg.fire_interval  <= RST_INTERVAL;
            r_cfg.random_seed    <= RST_SEED;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Read-back
    always_comb begin
        case (idx)
            REG_ENABLE:   prdata = DATA_W'(r_cfg.arp_enabled);
            REG_DIR:      prdata = DATA_W'(r_cfg.direction_down);
            REG_RANDOM:   prdata = DATA_W'(r_cfg.random_order);
            REG_PADS:     prdata = DATA_W'(r_cfg.pads_in_use);
            REG_INTERVAL: prdata = DATA_W'(r_cfg.fire_interval);
            REG_SEED:     prdata = r_cfg.random_seed;
            default:      prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;
    assign o_evt = cfg_evt;

endmodule

/* src/pad_arpeggiator_top.sv */
// Hold, release and non-firing tick requests complete in the cycle they are accepted.
// A firing tick stalls the input while the held pad and the position are reduced by the pad
// count through repeated subtraction, while the next pad is picked in stepping or random order,
// and for as long as an earlier fire still waits at the stalled output.
// The random pick runs five partial products through one registered 32x32 multiplier.
// Reset (i_rst_n low, synchronous) clears hold, pattern, time and output; generator is 1.
`include "pad_arpeggiator_top_macros.svh"

module pad_arpeggiator_top #(
    parameter int MAX_PADS = pad_arp_pkg::DEF_MAX_PADS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [pad_arp_pkg::OPC_W-1:0]   i_opcode,
    input  logic [pad_arp_pkg::PAD_W-1:0]   i_pad_index,
    input  logic                            i_release_all,
    input  logic [pad_arp_pkg::VEL_W-1:0]   i_hit_velocity,
    input  logic [pad_arp_pkg::DELAY_W-1:0] i_start_delay,
    // fire channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [pad_arp_pkg::PAD_W-1:0]   o_fire_pad,
    output logic [pad_arp_pkg::VEL_W-1:0]   o_fire_velocity,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pad_arp_pkg::ADDR_W-1:0]  paddr,
    input  logic [pad_arp_pkg::DATA_W-1:0]  pwdata,
    output logic [pad_arp_pkg::DATA_W-1:0]  prdata,
    output logic                            pready
);
    import pad_arp_pkg::*;

    localparam int PW = $clog2(MAX_PADS);
    localparam int CW = $clog2(MAX_PADS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PADS);

    t_cfg     cfg;
    t_cfg_evt cfg_evt;

    t_state             r_state, n_state;
    logic               r_holding, n_holding;
    logic [PAD_W-1:0]   r_held_pad, n_held_pad;
    logic [VEL_W-1:0]   r_held_vel, n_held_vel;
    logic [PW-1:0]      r_pos, n_pos;
    logic [TIME_W-1:0]  r_time, n_time;
    logic [GEN_W-1:0]   r_gen, n_gen;
    logic               r_out_valid, n_out_valid;
    logic [PAD_W-1:0]   r_fire_pad, n_fire_pad;
    logic [VEL_W-1:0]   r_fire_vel, n_fire_vel;
    logic [CW-1:0]      r_h, n_h;
    logic [CW-1:0]      r_p, n_p;
    logic [CW-1:0]      r_pad, n_pad;
    logic [GEN_W-1:0]   r_acc, n_acc;

    logic [MUL_W-1:0]   mul_a, mul_b;
    logic [2*MUL_W-1:0] prod;

    logic [CW-1:0]      n_cnt;
    logic [TIME_W-1:0]  interval;
    logic               fired;
    logic [TIME_W:0]    time_sum;
    logic [CW:0]        step_sum;
    logic [CW:0]        pos_inc;
    logic [CW-1:0]      pick;

    pad_arp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg),
        .o_evt   (cfg_evt)
    );

    pad_arp_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // Effective pad count and interval
    always_comb begin
        if (cfg.pads_in_use == '0 || 32'(cfg.pads_in_use) > MAX_PADS) begin
            n_cnt = CNT_MAX;
        end else begin
            n_cnt = CW'(cfg.pads_in_use);
        end
        interval = (cfg.fire_interval < ONE_SAMPLE) ? ONE_SAMPLE : cfg.fire_interval;
    end

    // Time update of a tick: reload on fire, then one sample off
    assign fired    = (r_time < ONE_SAMPLE);
    assign time_sum = {1'b0, r_time} + (fired ? {1'b0, interval} : '0) - {1'b0, ONE_SAMPLE};

    // Stepping order and position advance
    always_comb begin
        if (cfg.direction_down) begin
            step_sum = {1'b0, r_h} + {1'b0, n_cnt} - {1'b0, r_p};
        end else begin
            step_sum = {1'b0, r_h} + {1'b0, r_p};
        end
        if (step_sum >= {1'b0, n_cnt}) begin
            step_sum = step_sum - {1'b0, n_cnt};
        end
        pos_inc = {1'b0, r_p} + (CW+1)'(1);
    end

    assign pick = cfg.random_order ? r_acc[RND_POS +: CW] : r_pad;

    // Sequencer: next state, datapath and shared multiplier operands
    always_comb begin
        n_state     = r_state;
        n_holding   = r_holding;
        n_held_pad  = r_held_pad;
        n_held_vel  = r_held_vel;
        n_pos       = r_pos;
        n_time      = r_time;
        n_gen       = r_gen;
        n_h         = r_h;
        n_p         = r_p;
        n_pad       = r_pad;
        n_acc       = r_acc;
        n_fire_pad  = r_fire_pad;
        n_fire_vel  = r_fire_vel;
        n_out_valid = r_out_valid && i_out_stall;
        mul_a       = '0;
        mul_b       = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_opcode)
                        OP_HOLD: begin
                            if (cfg.arp_enabled && 32'(i_pad_index) < MAX_PADS) begin
                                n_holding  = 1'b1;
                                n_held_pad = i_pad_index;
                                n_held_vel = i_hit_velocity;
                                n_pos      = '0;
                                n_time     = TIME_W'({i_start_delay, {FRAC_W{1'b0}}});
                            end
                        end
                        OP_RELEASE: begin
                            if (r_holding && (i_release_all || i_pad_index == r_held_pad)) begin
                                n_holding = 1'b0;
                                n_pos     = '0;
                            end
                        end
                        OP_TICK: begin
                            if (r_holding) begin
                                n_time = time_sum[TIME_W-1:0];
                                if (fired) begin
                                    n_h     = CW'(r_held_pad);
                                    n_p     = CW'(r_pos);
                                    n_state = S_RED_H;
                                    if (cfg.random_order) begin
                                        n_gen = xorshift(r_gen);
                                    end
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // Reduce held pad by the pad count
            S_RED_H: begin
                if (r_h >= n_cnt) begin
                    n_h = r_h - n_cnt;
                end else begin
                    n_state = S_RED_P;
                end
            end
            // Reduce position, then advance it
            S_RED_P: begin
                if (r_p >= n_cnt) begin
                    n_p = r_p - n_cnt;
                end else begin
                    n_pos   = (pos_inc == {1'b0, n_cnt}) ? '0 : PW'(pos_inc);
                    n_state = cfg.random_order ? S_MUL_A : S_STEP;
                end
            end
            S_STEP: begin
                n_pad   = step_sum[CW-1:0];
                n_state = S_DONE;
            end
            // r = state * STAR_MUL mod 2^64 from three partial products
            S_MUL_A: begin
                mul_a   = r_gen[MUL_W-1:0];
                mul_b   = STAR_MUL[MUL_W-1:0];
                n_state = S_MUL_B;
            end
            S_MUL_B: begin
                mul_a   = r_gen[GEN_W-1:MUL_W];
                mul_b   = STAR_MUL[MUL_W-1:0];
                n_acc   = prod;
                n_state = S_MUL_C;
            end
            S_MUL_C: begin
                mul_a   = r_gen[MUL_W-1:0];
                mul_b   = STAR_MUL[GEN_W-1:MUL_W];
                n_acc   = r_acc + {prod[MUL_W-1:0], {MUL_W{1'b0}}};
                n_state = S_MUL_D;
            end
            S_MUL_D: begin
                n_acc   = r_acc + {prod[MUL_W-1:0], {MUL_W{1'b0}}};
                n_state = S_MUL_E;
            end
            // (r >> 11) * n in two partial products
            S_MUL_E: begin
                mul_a   = r_acc[RND_SHIFT +: MUL_W];
                mul_b   = MUL_W'(n_cnt);
                n_state = S_MUL_F;
            end
            S_MUL_F: begin
                mul_a   = MUL_W'(r_acc[GEN_W-1:RND_SHIFT+MUL_W]);
                mul_b   = MUL_W'(n_cnt);
                n_acc   = prod;
                n_state = S_MUL_G;
            end
            S_MUL_G: begin
                n_acc   = r_acc + {prod[MUL_W-1:0], {MUL_W{1'b0}}};
                n_state = S_DONE;
            end
            // Hand the fire to the output register once it is free
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_fire_pad  = PAD_W'(pick);
                    n_fire_vel  = r_held_vel;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // Configuration side effects
        if (cfg_evt.disable_hold) begin
            n_holding = 1'b0;
            n_pos     = '0;
        end
        if (cfg_evt.load_seed) begin
            n_gen = (cfg_evt.seed == '0) ? RST_SEED : cfg_evt.seed;
        end
    end

    // Control and arpeggio state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_holding   <= 1'b0;
            r_held_pad  <= '0;
            r_held_vel  <= '0;
            r_pos       <= '0;
            r_time      <= '0;
            r_gen       <= RST_SEED;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_holding   <= n_holding;
            r_held_pad  <= n_held_pad;
            r_held_vel  <= n_held_vel;
            r_pos       <= n_pos;
            r_time      <= n_time;
            r_gen       <= n_gen;
            r_out_valid <= n_out_valid;
        end
    end

    // Working registers and output payload
    always_ff @(posedge i_clk) begin
        r_h        <= n_h;
        r_p        <= n_p;
        r_pad      <= n_pad;
        r_acc      <= n_acc;
        r_fire_pad <= n_fire_pad;
        r_fire_vel <= n_fire_vel;
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_fire_pad      = r_fire_pad;
    assign o_fire_velocity = r_fire_vel;

    `ARP_ASSERT_NOW(a_idle_pos_zero, !r_holding, r_pos == '0, "position kept without a hold")
    `ARP_ASSERT_NOW(a_gen_nonzero, 1'b1, r_gen != '0, "generator state reached zero")
    `ARP_ASSERT_NOW(a_held_reduced, r_state == S_RED_P, r_h < n_cnt, "held pad not reduced")
    `ARP_ASSERT_NOW(a_out_from_done, $rose(r_out_valid), $past(r_state) == S_DONE, "stray fire")
    `ARP_ASSERT_NEXT(a_done_frees, (r_state == S_DONE) && !i_out_stall, r_out_valid && (r_state == S_IDLE), "fire not handed over")

endmodule
